### sv/ppsa_pkg.sv
// shared constants, types and pixel helpers for the packed pixel store
package ppsa_pkg;

  // store geometry
  localparam int STORE_BYTES = 65536;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int MAX_DIM     = 4096;

  // field widths
  localparam int COORD_W = 12;
  localparam int PITCH_W = 15;
  localparam int FMT_W   = 4;
  localparam int DATA_W  = 32;
  localparam int OFF_W   = COORD_W + 2;
  localparam int LIN_W   = COORD_W + PITCH_W + 1;

  // register map
  localparam int PADDR_W = 3;
  localparam logic REG_ROW_PITCH    = 1'b0;
  localparam logic REG_PIXEL_FORMAT = 1'b1;
  localparam logic [PITCH_W-1:0] PITCH_RESET = PITCH_W'(4096);

  // request codes
  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // pixel formats
  localparam logic [FMT_W-1:0] FMT_MONO   = 4'd0;
  localparam logic [FMT_W-1:0] FMT_NIBBLE = 4'd1;
  localparam logic [FMT_W-1:0] FMT_U8     = 4'd2;
  localparam logic [FMT_W-1:0] FMT_S8     = 4'd3;
  localparam logic [FMT_W-1:0] FMT_S16    = 4'd4;
  localparam logic [FMT_W-1:0] FMT_U16    = 4'd5;
  localparam logic [FMT_W-1:0] FMT_RGB24  = 4'd6;
  localparam logic [FMT_W-1:0] FMT_RGBA32 = 4'd7;

  localparam logic [7:0] BIT_ONE  = 8'h01;
  localparam logic [7:0] NIB_HIGH = 8'hF0;
  localparam logic [7:0] NIB_LOW  = 8'h0F;

  // address generator result
  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [1:0]        last_idx;
    logic              oor;
    logic              unsup;
  } agen_t;

  // unpack a gathered pixel word into the read value
  function automatic logic [DATA_W-1:0] pixel_decode(
    input logic [FMT_W-1:0]  fmt,
    input logic [2:0]        col_lo,
    input logic [DATA_W-1:0] acc
  );
    logic [DATA_W-1:0] rv;
    rv = '0;
    unique case (fmt)
      FMT_MONO:   rv = {{(DATA_W-1){1'b0}}, acc[~col_lo]};
      FMT_NIBBLE: rv = col_lo[0] ? {{(DATA_W-4){1'b0}}, acc[3:0]}
                                 : {{(DATA_W-4){1'b0}}, acc[7:4]};
      FMT_U8:     rv = {{(DATA_W-8){1'b0}}, acc[7:0]};
      FMT_S8:     rv = {{(DATA_W-8){acc[7]}}, acc[7:0]};
      FMT_S16:    rv = {{(DATA_W-16){acc[15]}}, acc[15:0]};
      FMT_U16:    rv = {{(DATA_W-16){1'b0}}, acc[15:0]};
      FMT_RGB24:  rv = {{(DATA_W-24){1'b0}}, acc[23:0]};
      FMT_RGBA32: rv = acc;
      default:    rv = '0;
    endcase
    return rv;
  endfunction

  // merge a sub-byte pixel into the old byte
  function automatic logic [7:0] pixel_merge(
    input logic [FMT_W-1:0]  fmt,
    input logic [2:0]        col_lo,
    input logic [DATA_W-1:0] wv,
    input logic [7:0]        old
  );
    logic [7:0] mask;
    logic [7:0] b;
    mask = BIT_ONE << (~col_lo);
    b    = old;
    if (fmt == FMT_MONO) begin
      b = (|wv) ? (old | mask) : (old & ~mask);
    end else if (col_lo[0]) begin
      b = (old & NIB_HIGH) | (wv[7:0] & NIB_LOW);
    end else begin
      b = (old & NIB_LOW) | {wv[3:0], 4'h0};
    end
    return b;
  endfunction

endpackage

### sv/ppsa_ram.sv
// generic single-port ram with registered read
module ppsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### sv/ppsa_agen.sv
// two-stage byte address generator with range check
module ppsa_agen (
  input  logic                            clk,
  input  logic                            start,
  input  logic [ppsa_pkg::COORD_W-1:0]    column,
  input  logic [ppsa_pkg::COORD_W-1:0]    row,
  input  logic [ppsa_pkg::PITCH_W-1:0]    row_pitch,
  input  logic [ppsa_pkg::FMT_W-1:0]      pixel_format,
  output ppsa_pkg::agen_t                 agen
);
  import ppsa_pkg::*;

  // stage 1
  logic [COORD_W+PITCH_W-1:0] prod;
  logic [OFF_W-1:0]           off;
  logic [1:0]                 last1;
  logic                       coord_oor1;
  logic                       unsup1;
  // stage 2
  logic [LIN_W-1:0]           lin;
  logic [1:0]                 last2;
  logic                       coord_oor2;
  logic                       unsup2;

  logic [OFF_W-1:0]           off_next;
  logic [1:0]                 last_next;
  logic [LIN_W-1:0]           end_addr;

  always_comb begin
    off_next  = '0;
    last_next = 2'd0;
    unique case (pixel_format)
      FMT_MONO:          off_next = OFF_W'(column >> 3);
      FMT_NIBBLE:        off_next = OFF_W'(column >> 1);
      FMT_U8, FMT_S8:    off_next = OFF_W'(column);
      FMT_S16, FMT_U16: begin
        off_next  = OFF_W'({column, 1'b0});
        last_next = 2'd1;
      end
      FMT_RGB24: begin
        off_next  = OFF_W'(column) + OFF_W'({column, 1'b0});
        last_next = 2'd2;
      end
      FMT_RGBA32: begin
        off_next  = OFF_W'({column, 2'b00});
        last_next = 2'd3;
      end
      default:           off_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod       <= row * row_pitch;
      off        <= off_next;
      last1      <= last_next;
      coord_oor1 <= (int'(column) >= MAX_DIM) || (int'(row) >= MAX_DIM);
      unsup1     <= pixel_format > FMT_RGBA32;
    end
    lin        <= LIN_W'(prod) + LIN_W'(off);
    last2      <= last1;
    coord_oor2 <= coord_oor1;
    unsup2     <= unsup1;
  end

  assign end_addr = lin + LIN_W'(last2);

  always_comb begin
    agen.base     = lin[ADDR_W-1:0];
    agen.last_idx = last2;
    agen.unsup    = unsup2;
    agen.oor      = !unsup2 && (coord_oor2 || (end_addr >= LIN_W'(STORE_BYTES)));
  end

endmodule

### sv/packed_pixel_store_access.sv
// top level: packed pixel store with byte sequencer and config registers
//
// Serves one pixel read or write per transfer against a 64 KiB byte store,
// addressed as row * row_pitch plus the column scaled by the pixel size.
// Every pixel goes through one single-port byte ram, one byte per access,
// so the byte count of the pixel format sets the latency. Each request
// passes the pitch multiply, then the address add with the range check;
// then a read of an n-byte pixel does one read plus one capture per byte,
// a full-byte write one write per byte, a 1-bit or 4-bit write a read, a
// capture and a write back, and an out-of-range or unsupported-format
// request goes straight to loading the result in the output register. The
// next request can be taken in the cycle after the load, and the load
// waits while the output register still holds an unaccepted result.
// One request is in flight at a time; the output register lets the next
// request in while a result still waits. The store contents are undefined
// until written. Registers sit on the apb port: row_pitch at 0x0,
// pixel_format at 0x4; write them only while the block is idle.
module packed_pixel_store_access (
  input  logic                           clk,
  input  logic                           rst,
  // apb config port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ppsa_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  // request channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           req_type,
  input  logic [ppsa_pkg::COORD_W-1:0]   column,
  input  logic [ppsa_pkg::COORD_W-1:0]   row,
  input  logic [ppsa_pkg::DATA_W-1:0]    write_value,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [ppsa_pkg::DATA_W-1:0]    read_value,
  output logic                           out_of_range
);
  import ppsa_pkg::*;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;  // waiting for a request
  localparam logic [2:0] S_ADR  = 3'd1;  // address add in flight
  localparam logic [2:0] S_GO   = 3'd2;  // address and range known, dispatch
  localparam logic [2:0] S_RD   = 3'd3;  // issue byte read
  localparam logic [2:0] S_RDW  = 3'd4;  // capture byte read data
  localparam logic [2:0] S_WR   = 3'd5;  // write one byte
  localparam logic [2:0] S_FIN  = 3'd6;  // load the output register

  // config registers
  logic [PITCH_W-1:0] row_pitch;
  logic [FMT_W-1:0]   pixel_format;

  // request context
  logic               is_write;
  logic [2:0]         col_lo;
  logic [DATA_W-1:0]  wv;
  logic               oor_q;

  // sequencer
  logic [2:0]         state;
  logic [2:0]         state_next;
  logic [1:0]         idx;
  logic [DATA_W-1:0]  acc;

  agen_t              agen;

  // ram port
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_addr;
  logic [7:0]         ram_wdata;
  logic [7:0]         ram_rdata;

  logic               in_fire;
  logic               out_free;
  logic               cfg_wr;
  logic               sub_byte;
  logic [7:0]         wv_byte;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign sub_byte = (pixel_format == FMT_MONO) || (pixel_format == FMT_NIBBLE);

  // apb registers; the low address bits below the word are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      row_pitch    <= PITCH_RESET;
      pixel_format <= FMT_RGBA32;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_ROW_PITCH:    row_pitch    <= pwdata[PITCH_W-1:0];
        REG_PIXEL_FORMAT: pixel_format <= pwdata[FMT_W-1:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_ROW_PITCH:    prdata = 32'(row_pitch);
      REG_PIXEL_FORMAT: prdata = 32'(pixel_format);
      default:          prdata = '0;
    endcase
  end

  // pitch multiply, column scaling and range check
  ppsa_agen u_agen (
    .clk          (clk),
    .start        (in_fire),
    .column       (column),
    .row          (row),
    .row_pitch    (row_pitch),
    .pixel_format (pixel_format),
    .agen         (agen)
  );

  // little-endian byte lane of the write value
  always_comb begin
    unique case (idx)
      2'd0:    wv_byte = wv[7:0];
      2'd1:    wv_byte = wv[15:8];
      2'd2:    wv_byte = wv[23:16];
      2'd3:    wv_byte = wv[31:24];
      default: wv_byte = wv[7:0];
    endcase
  end

  // byte store port: at most one access per cycle, sub-byte writes merge the
  // byte captured in acc
  always_comb begin
    ram_addr  = agen.base + ADDR_W'(idx);
    ram_we    = (state == S_WR);
    ram_wdata = sub_byte ? pixel_merge(pixel_format, col_lo, wv, acc[7:0]) : wv_byte;
  end

  ppsa_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_fire) begin
        state_next = S_ADR;
      end
      S_ADR:  state_next = S_GO;
      S_GO: begin
        if (agen.unsup || agen.oor) begin
          state_next = S_FIN;
        end else if (is_write && !sub_byte) begin
          state_next = S_WR;
        end else begin
          state_next = S_RD;
        end
      end
      S_RD:   state_next = S_RDW;
      S_RDW: begin
        if (is_write) begin
          state_next = S_WR;  // read-modify-write of a sub-byte pixel
        end else if (idx == agen.last_idx) begin
          state_next = S_FIN;
        end else begin
          state_next = S_RD;
        end
      end
      S_WR: if (idx == agen.last_idx) begin
        state_next = S_FIN;
      end
      S_FIN: if (out_free) begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // request context and byte gather
  always_ff @(posedge clk) begin
    if (in_fire) begin
      is_write <= (req_type == REQ_WRITE);
      col_lo   <= column[2:0];
      wv       <= write_value;
    end
    unique case (state)
      S_GO: begin
        idx   <= 2'd0;
        acc   <= '0;
        oor_q <= agen.oor;
      end
      S_RDW: begin
        unique case (idx)
          2'd0:    acc[7:0]   <= ram_rdata;
          2'd1:    acc[15:8]  <= ram_rdata;
          2'd2:    acc[23:16] <= ram_rdata;
          2'd3:    acc[31:24] <= ram_rdata;
          default: acc[7:0]   <= ram_rdata;
        endcase
        if (!is_write && idx != agen.last_idx) begin
          idx <= idx + 2'd1;
        end
      end
      S_WR: if (idx != agen.last_idx) begin
        idx <= idx + 2'd1;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && out_free) begin
      read_value   <= is_write ? '0 : pixel_decode(pixel_format, col_lo, acc);
      out_of_range <= oor_q;
    end
  end

endmodule
